>>> hdl/meter_response_frame_parser_assert.svh
// Assertion macros used by the meter reply parser checker.
// No dependencies; expects clk_i and rst_ni in the scope of each use.
`ifndef METER_RESPONSE_FRAME_PARSER_ASSERT_SVH
`define METER_RESPONSE_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication.
`define MRFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mrfp check failed");

// Next-cycle implication.
`define MRFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mrfp check failed");

`endif

>>> hdl/mrfp_pkg.sv
// Shared types and constants of the meter reply frame parser.
// No dependencies.
package mrfp_pkg;

  localparam int unsigned BUF_BYTES   = 64;
  localparam int unsigned POS_W       = $clog2(BUF_BYTES + 1);
  localparam int unsigned CMP_W       = (POS_W > 8) ? POS_W : 8;
  localparam int unsigned DROP_W      = CMP_W + 1;
  localparam int unsigned ADDR_BYTES  = 6;
  localparam int unsigned ADDR_W      = 8 * ADDR_BYTES;
  localparam int unsigned VALUE_BYTES = 5;
  localparam int unsigned RAW_W       = 8 * VALUE_BYTES;
  localparam int unsigned READING_W   = 34;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0]           START_BYTE  = 8'h68;
  localparam logic [7:0]           BYTE_OFFSET = 8'h33;
  localparam logic [RAW_W-1:0]     RAW_RESET   = {VALUE_BYTES{BYTE_OFFSET}};
  localparam logic [READING_W-1:0] READING_MAX = 34'd16666666665;
  localparam logic [3:0]           PREAMBLE_RESET = 4'd4;
  localparam logic [2:0]           DIGITS_RESET   = 3'd4;

  // Fixed frame offsets relative to the start byte
  localparam int unsigned REL_CTRL = 8;
  localparam int unsigned REL_LEN  = 9;
  localparam int unsigned REL_DATA = 10;
  localparam int unsigned DATA_VALUE_OFS = 4;

  typedef enum logic {
    REG_PREAMBLE_LEN = 1'b0,
    REG_DIGIT_BYTES  = 1'b1
  } reg_idx_e;

  // One parsed frame handed from front end to back end
  typedef struct packed {
    logic              frame_ok;
    logic              reading_ok;
    logic [ADDR_W-1:0] address;
    logic [7:0]        control;
    logic [RAW_W-1:0]  raw;
  } frame_rec_t;

  // Queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> hdl/meter_response_frame_parser.sv
// Meter reply frame parser: one byte per cycle in unless stalled, one result per frame out.
// Top level; depends on mrfp_pkg, mrfp_front, mrfp_queue and mrfp_back.
//
// Bytes of a received meter reply enter on the input channel, one per transfer, with
// frame_start_i marking the first byte of a buffer. After preamble_len wake-up bytes the
// front end checks the 0x68 start byte, captures six address bytes, the control code and
// the length, and keeps a modulo-256 sum through the data field. At the checksum byte a
// frame record goes into a four-entry queue; the back end decodes the BCD value (0x33
// removed per byte, value_digit_bytes bytes from data offset 4) in a five-step pipeline,
// one multiply-by-100 per step, and presents the result in an output register.
// Throughput is one byte per clock: in_ready_o drops only when the queue is full, which
// needs the output held for several frames. Frames whose checksum would fall at or
// beyond buffer position 64 are dropped without a result. Registers (APB, 32-bit):
// 0x0 preamble_len[3:0] (reset 4), 0x4 value_digit_bytes[2:0] (reset 4); change them
// only while no frame is in flight.
module meter_response_frame_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           frame_start_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           frame_ok_o,
  output logic [mrfp_pkg::ADDR_W-1:0]    meter_address_o,
  output logic [7:0]                     control_code_o,
  output logic [mrfp_pkg::READING_W-1:0] reading_o,
  output logic                           reading_ok_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import mrfp_pkg::*;

  logic [3:0]  preamble_len_q;
  logic [2:0]  digit_bytes_q;
  reg_idx_e    reg_idx;
  logic        cfg_wr;
  logic        accept;
  logic        push, pop;
  frame_rec_t  rec_in, rec_out;
  queue_stat_t qstat;

  // --- configuration port ---
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_len_q <= PREAMBLE_RESET;
      digit_bytes_q  <= DIGITS_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PREAMBLE_LEN: preamble_len_q <= pwdata[3:0];
        REG_DIGIT_BYTES:  digit_bytes_q  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PREAMBLE_LEN: prdata = {28'b0, preamble_len_q};
      REG_DIGIT_BYTES:  prdata = {29'b0, digit_bytes_q};
      default:          prdata = '0;
    endcase
  end

  // --- input side: stall only when the frame queue has no room ---
  assign in_ready_o = !qstat.full;
  assign accept     = in_valid_i && in_ready_o;

  mrfp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .rx_byte_i      (rx_byte_i),
    .frame_start_i  (frame_start_i),
    .preamble_len_i (preamble_len_q),
    .push_o         (push),
    .rec_o          (rec_in)
  );

  mrfp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec_in),
    .pop_i  (pop),
    .rec_o  (rec_out),
    .stat_o (qstat)
  );

  mrfp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .digit_bytes_i   (digit_bytes_q),
    .rec_i           (rec_out),
    .stat_i          (qstat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_ok_o      (frame_ok_o),
    .meter_address_o (meter_address_o),
    .control_code_o  (control_code_o),
    .reading_o       (reading_o),
    .reading_ok_o    (reading_ok_o)
  );

endmodule

>>> hdl/mrfp_front.sv
// Front end: byte position tracking, field capture and checksum.
// Depends on mrfp_pkg.
module mrfp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_start_i,
  input  logic [3:0]          preamble_len_i,
  output logic                push_o,
  output mrfp_pkg::frame_rec_t rec_o
);
  import mrfp_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d, pos_e;
  logic              dropped_q, dropped_d, dropped_e;
  logic [7:0]        sum_q, sum_d, sum_e;
  logic [ADDR_W-1:0] addr_q, addr_d, addr_e;
  logic [7:0]        ctrl_q, ctrl_d, ctrl_e;
  logic [7:0]        len_q, len_d, len_e;
  logic [RAW_W-1:0]  raw_q, raw_d, raw_e;
  logic              sok_q, sok_d, sok_e;

  logic [POS_W-1:0]  pre_ext;
  logic [POS_W-1:0]  rel;
  logic [POS_W-1:0]  dofs;
  logic              past_pre;
  logic              in_data;
  logic              at_sum;
  logic              frame_ok;
  logic              raw_ge;

  always_comb begin
    // A frame start clears the frame state before this byte is looked at
    if (frame_start_i) begin
      pos_e = '0; dropped_e = 1'b0; sum_e = '0; addr_e = '0;
      ctrl_e = '0; len_e = '0; raw_e = RAW_RESET; sok_e = 1'b0;
    end else begin
      pos_e = pos_q; dropped_e = dropped_q; sum_e = sum_q; addr_e = addr_q;
      ctrl_e = ctrl_q; len_e = len_q; raw_e = raw_q; sok_e = sok_q;
    end

    pre_ext  = POS_W'(preamble_len_i);
    past_pre = (pos_e >= pre_ext);
    rel      = pos_e - pre_ext;
    dofs     = rel - POS_W'(REL_DATA);
    in_data  = (CMP_W'(dofs) < CMP_W'(len_e));
    at_sum   = !dropped_e && past_pre && (rel >= POS_W'(REL_DATA)) && !in_data;

    frame_ok = sok_e && (sum_e == rx_byte_i);
    raw_ge   = (raw_e[7:0] >= BYTE_OFFSET) && (raw_e[15:8] >= BYTE_OFFSET) &&
               (raw_e[23:16] >= BYTE_OFFSET);

    pos_d = pos_e; dropped_d = dropped_e; sum_d = sum_e; addr_d = addr_e;
    ctrl_d = ctrl_e; len_d = len_e; raw_d = raw_e; sok_d = sok_e;

    if (!dropped_e) begin
      if (past_pre) begin
        if (rel < POS_W'(REL_DATA)) begin
          sum_d = sum_e + rx_byte_i;
          if (rel == '0) sok_d = (rx_byte_i == START_BYTE);
          for (int j = 0; j < ADDR_BYTES; j++) begin
            if (rel == POS_W'(j + 1)) addr_d[8*j +: 8] = rx_byte_i;
          end
          if (rel == POS_W'(REL_CTRL)) ctrl_d = rx_byte_i;
          if (rel == POS_W'(REL_LEN)) begin
            len_d = rx_byte_i;
            // checksum would land beyond the receive buffer
            if (DROP_W'(preamble_len_i) + DROP_W'(REL_DATA) + DROP_W'(rx_byte_i)
                >= DROP_W'(BUF_BYTES)) dropped_d = 1'b1;
          end
        end else if (in_data) begin
          sum_d = sum_e + rx_byte_i;
          for (int k = 0; k < VALUE_BYTES; k++) begin
            if (dofs == POS_W'(k + DATA_VALUE_OFS)) raw_d[8*k +: 8] = rx_byte_i;
          end
        end else begin
          dropped_d = 1'b1;
        end
      end
      if (pos_e < POS_W'(BUF_BYTES)) pos_d = pos_e + 1'b1;
    end

    push_o           = accept_i && at_sum;
    rec_o.frame_ok   = frame_ok;
    rec_o.reading_ok = frame_ok && raw_ge;
    rec_o.address    = addr_e;
    rec_o.control    = ctrl_e;
    rec_o.raw        = raw_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      dropped_q <= 1'b1;
    end else if (accept_i) begin
      pos_q     <= pos_d;
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sum_q  <= sum_d;
      addr_q <= addr_d;
      ctrl_q <= ctrl_d;
      len_q  <= len_d;
      raw_q  <= raw_d;
      sok_q  <= sok_d;
    end
  end

endmodule

>>> hdl/mrfp_queue.sv
// Small FIFO of parsed frames between front end and back end.
// Depends on mrfp_pkg.
module mrfp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mrfp_pkg::frame_rec_t  rec_i,
  input  logic                  pop_i,
  output mrfp_pkg::frame_rec_t  rec_o,
  output mrfp_pkg::queue_stat_t stat_o
);
  import mrfp_pkg::*;

  frame_rec_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign rec_o        = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

endmodule

>>> hdl/mrfp_back.sv
// Back end: BCD digit decode and Horner pipeline, result register.
// Depends on mrfp_pkg.
module mrfp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [2:0]                digit_bytes_i,
  input  mrfp_pkg::frame_rec_t      rec_i,
  input  mrfp_pkg::queue_stat_t     stat_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      frame_ok_o,
  output logic [mrfp_pkg::ADDR_W-1:0]    meter_address_o,
  output logic [7:0]                control_code_o,
  output logic [mrfp_pkg::READING_W-1:0] reading_o,
  output logic                      reading_ok_o
);
  import mrfp_pkg::*;

  typedef struct packed {
    logic                              frame_ok;
    logic                              reading_ok;
    logic [ADDR_W-1:0]                 address;
    logic [7:0]                        control;
    logic [READING_W-1:0]              acc;
    logic [VALUE_BYTES-1:0][7:0]       digits;
  } stage_t;

  stage_t                 st_q [VALUE_BYTES+1];
  stage_t                 st_d [VALUE_BYTES+1];
  logic [VALUE_BYTES:0]   vld_q;
  stage_t                 head;
  logic [2:0]             n_eff;
  logic                   adv;
  logic [7:0]             dd;
  logic [7:0]             hi;

  function automatic logic [READING_W-1:0] mul100_add(logic [READING_W-1:0] a,
                                                      logic [7:0] v);
    return (a << 6) + (a << 5) + (a << 2) + READING_W'(v);
  endfunction

  always_comb begin
    if (digit_bytes_i == 3'd0)     n_eff = 3'd1;
    else if (digit_bytes_i > 3'd5) n_eff = 3'd5;
    else                           n_eff = digit_bytes_i;

    head.frame_ok   = rec_i.frame_ok;
    head.reading_ok = rec_i.reading_ok;
    head.address    = rec_i.address;
    head.control    = rec_i.control;
    head.acc        = '0;
    dd = '0;
    hi = '0;
    for (int k = 0; k < VALUE_BYTES; k++) begin
      dd = rec_i.raw[8*k +: 8] - BYTE_OFFSET;
      hi = {4'b0, dd[7:4]};
      head.digits[k] = (3'(k) < n_eff) ? (hi << 3) + (hi << 1) + {4'b0, dd[3:0]} : 8'd0;
    end
  end

  // next stage contents: one multiply-by-100 step per stage, most significant digit first
  always_comb begin
    st_d[0] = head;
    for (int j = 1; j <= VALUE_BYTES; j++) begin
      st_d[j]     = st_q[j-1];
      st_d[j].acc = mul100_add(st_q[j-1].acc, st_q[j-1].digits[VALUE_BYTES-j]);
    end
  end

  // whole pipeline moves together; stalls only on a held result
  assign adv   = !vld_q[VALUE_BYTES] || out_ready_i;
  assign pop_o = adv && !stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[VALUE_BYTES-1:0], pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j <= VALUE_BYTES; j++) begin
        st_q[j] <= st_d[j];
      end
    end
  end

  assign out_valid_o     = vld_q[VALUE_BYTES];
  assign frame_ok_o      = st_q[VALUE_BYTES].frame_ok;
  assign reading_ok_o    = st_q[VALUE_BYTES].reading_ok;
  assign meter_address_o = st_q[VALUE_BYTES].address;
  assign control_code_o  = st_q[VALUE_BYTES].control;
  assign reading_o       = st_q[VALUE_BYTES].acc;

endmodule

>>> hdl/mrfp_checker.sv
// Port-level checks for the meter reply frame parser, bound to the top level.
// Depends on mrfp_pkg and meter_response_frame_parser_assert.svh.
`include "meter_response_frame_parser_assert.svh"

module mrfp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           frame_ok_o,
  input logic [mrfp_pkg::ADDR_W-1:0]    meter_address_o,
  input logic [mrfp_pkg::READING_W-1:0] reading_o,
  input logic                           reading_ok_o,
  input logic                           pready
);
  import mrfp_pkg::*;

  `MRFP_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(reading_o) && $stable(meter_address_o))
  `MRFP_ASSERT_IMP(a_rok_needs_fok, out_valid_o && reading_ok_o, frame_ok_o)
  `MRFP_ASSERT_IMP(a_reading_max, out_valid_o, reading_o <= READING_MAX)
  `MRFP_ASSERT_IMP(a_pready_high, 1'b1, pready)

endmodule

bind meter_response_frame_parser mrfp_checker u_mrfp_checker (.*);
